@@ design/bgmc_pkg.sv @@
// ----------------------------------------------------------------------------
// bgmc_pkg: shared types and constants for the button gesture mode cycler
// Item structs, event codes, register map and register reset values.
// ----------------------------------------------------------------------------
package bgmc_pkg;

    localparam int unsigned STAMP_W   = 32;
    localparam int unsigned TIME_W    = 16;
    localparam int unsigned CLICK_W   = 8;
    localparam int unsigned STYLE_W   = 2;
    localparam int unsigned ADDR_W    = 4;
    localparam int unsigned DATA_W    = 32;

    localparam logic [CLICK_W-1:0] CLICK_MAX  = 8'd255;
    localparam logic [STYLE_W-1:0] DRAW_LAST  = 2'd2;
    localparam logic [STYLE_W-1:0] THEME_LAST = 2'd2;

    // register indexes, byte address is 4 * index
    localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [1:0] REG_CLICK_GAP  = 2'd2;

    localparam logic [TIME_W-1:0] DEBOUNCE_RST   = 16'd30;
    localparam logic [TIME_W-1:0] LONG_PRESS_RST = 16'd800;
    localparam logic [TIME_W-1:0] CLICK_GAP_RST  = 16'd350;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_LONG   = 2'd1,
        EV_SINGLE = 2'd2,
        EV_MULTI  = 2'd3
    } t_event;

    typedef struct packed {
        logic               raw_pressed;
        logic [STAMP_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         event_code;
        logic               stable_level;
        logic [STYLE_W-1:0] draw_style;
        logic [STYLE_W-1:0] theme_style;
        logic [1:0]         speed_slot;
    } t_out_item;

    typedef struct packed {
        logic [TIME_W-1:0] debounce_time;
        logic [TIME_W-1:0] long_press_time;
        logic [TIME_W-1:0] click_gap_time;
    } t_cfg;

endpackage

@@ design/bgmc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// bgmc_cfg_regs: configuration register file
// APB-style write/read of the three timing registers; zero wait states.
// ----------------------------------------------------------------------------
module bgmc_cfg_regs
    import bgmc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg        r_cfg;
    logic        w_wr;
    logic [1:0]  w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time   <= DEBOUNCE_RST;
            r_cfg.long_press_time <= LONG_PRESS_RST;
            r_cfg.click_gap_time  <= CLICK_GAP_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_DEBOUNCE:   r_cfg.debounce_time   <= pwdata[TIME_W-1:0];
                REG_LONG_PRESS: r_cfg.long_press_time <= pwdata[TIME_W-1:0];
                REG_CLICK_GAP:  r_cfg.click_gap_time  <= pwdata[TIME_W-1:0];
                default: ;  // unmapped address: drop the write
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_DEBOUNCE:   prdata = DATA_W'(r_cfg.debounce_time);
            REG_LONG_PRESS: prdata = DATA_W'(r_cfg.long_press_time);
            REG_CLICK_GAP:  prdata = DATA_W'(r_cfg.click_gap_time);
            default:        prdata = '0;
        endcase
    end

endmodule

@@ design/button_gesture_mode_cycler_core.sv @@
// ----------------------------------------------------------------------------
// button_gesture_mode_cycler_core: debounced button gestures to mode changes
// Debounce, long press, single and multi click on polled samples.
//
//   channel  | valid       | stall       | payload
//   ---------+-------------+-------------+-------------------------
//   in       | i_in_valid  | o_in_stall  | i_in_data  (t_in_item)
//   out      | o_out_valid | i_out_stall | o_out_data (t_out_item)
//   config   | psel/penable/pwrite, pready always high, paddr 4 bits
//
// One item per cycle sustained while the output is not stalled; each item
// passes the input register, then the result register. All gesture state
// updates in the cycle an item moves from the input register to the result
// register. Synchronous reset to documented values; r_in, r_out not reset.
// A stalled result holds the result register; the input register still takes
// an item when empty, then stalls the input side.
// ----------------------------------------------------------------------------
module button_gesture_mode_cycler_core
    import bgmc_pkg::*;
#(
    parameter int unsigned SPEED_PRESET_COUNT = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int unsigned SPEED_W = $clog2(SPEED_PRESET_COUNT);
    localparam logic [SPEED_W-1:0] SPEED_LAST = SPEED_W'(SPEED_PRESET_COUNT - 1);

    t_cfg w_cfg;

    bgmc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // pipeline registers
    logic               r_in_valid;
    t_in_item           r_in;
    logic               r_out_valid;
    t_out_item          r_out;

    // gesture state
    logic               r_last_raw,   n_last_raw;
    logic [STAMP_W-1:0] r_edge_stamp, n_edge_stamp;
    logic               r_level,      n_level;
    logic [STAMP_W-1:0] r_press_stamp, n_press_stamp;
    logic [STAMP_W-1:0] r_rel_stamp,  n_rel_stamp;
    logic               r_long_done,  n_long_done;
    logic [CLICK_W-1:0] r_click_count, n_click_count;
    logic [STYLE_W-1:0] r_draw,       n_draw;
    logic [STYLE_W-1:0] r_theme,      n_theme;
    logic [SPEED_W-1:0] r_speed,      n_speed;
    t_out_item          n_out;

    logic               w_out_adv;
    logic               w_step;
    logic [STAMP_W-1:0] w_edge_age;
    logic [STAMP_W-1:0] w_press_age;
    logic [STAMP_W-1:0] w_rel_age;
    logic               w_settled;
    logic               w_long_hit;
    t_event             w_event;
    logic [SPEED_W+1:0] w_speed_ext;

    assign w_out_adv   = !r_out_valid || !i_out_stall;
    assign w_step      = r_in_valid && w_out_adv;
    assign o_in_stall  = r_in_valid && !w_out_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_last_raw    = r_last_raw;
        n_edge_stamp  = r_edge_stamp;
        n_level       = r_level;
        n_press_stamp = r_press_stamp;
        n_rel_stamp   = r_rel_stamp;
        n_long_done   = r_long_done;
        n_click_count = r_click_count;
        n_draw        = r_draw;
        n_theme       = r_theme;
        n_speed       = r_speed;
        w_event       = EV_NONE;
        w_long_hit    = 1'b0;

        if (r_in.raw_pressed != r_last_raw) begin
            n_last_raw   = r_in.raw_pressed;
            n_edge_stamp = r_in.now_ms;
        end
        w_edge_age = r_in.now_ms - n_edge_stamp;
        w_settled  = w_edge_age >= STAMP_W'(w_cfg.debounce_time);

        if (w_settled && (r_in.raw_pressed != r_level)) begin
            n_level = r_in.raw_pressed;
            if (r_in.raw_pressed) begin
                n_press_stamp = r_in.now_ms;
                n_long_done   = 1'b0;
            end else begin
                n_rel_stamp = r_in.now_ms;
                // a release that ends a long press adds no click
                if (!r_long_done && (r_click_count != CLICK_MAX)) begin
                    n_click_count = r_click_count + CLICK_W'(1);
                end
            end
        end

        w_press_age = r_in.now_ms - n_press_stamp;
        w_rel_age   = r_in.now_ms - n_rel_stamp;

        if (w_settled && n_level && !n_long_done &&
            (w_press_age >= STAMP_W'(w_cfg.long_press_time))) begin
            w_event       = EV_LONG;
            w_long_hit    = 1'b1;
            n_long_done   = 1'b1;
            n_click_count = '0;
        end

        if (w_settled && !w_long_hit && !n_level && (n_click_count != '0) &&
            (w_rel_age >= STAMP_W'(w_cfg.click_gap_time))) begin
            if (n_click_count == CLICK_W'(1)) begin
                w_event = EV_SINGLE;
                // advance the combined mode: draw is the low digit, base 3
                if (r_draw == DRAW_LAST) begin
                    n_draw  = '0;
                    n_theme = (r_theme == THEME_LAST) ? '0 : r_theme + STYLE_W'(1);
                end else begin
                    n_draw = r_draw + STYLE_W'(1);
                end
            end else begin
                w_event = EV_MULTI;
                n_speed = (r_speed == SPEED_LAST) ? '0 : r_speed + SPEED_W'(1);
            end
            n_click_count = '0;
        end

        w_speed_ext        = (SPEED_W + 2)'(n_speed);
        n_out.event_code   = w_event;
        n_out.stable_level = n_level;
        n_out.draw_style   = n_draw;
        n_out.theme_style  = n_theme;
        n_out.speed_slot   = w_speed_ext[1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_last_raw    <= 1'b0;
            r_edge_stamp  <= '0;
            r_level       <= 1'b0;
            r_press_stamp <= '0;
            r_rel_stamp   <= '0;
            r_long_done   <= 1'b0;
            r_click_count <= '0;
            r_draw        <= '0;
            r_theme       <= '0;
            r_speed       <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_step) begin
                r_last_raw    <= n_last_raw;
                r_edge_stamp  <= n_edge_stamp;
                r_level       <= n_level;
                r_press_stamp <= n_press_stamp;
                r_rel_stamp   <= n_rel_stamp;
                r_long_done   <= n_long_done;
                r_click_count <= n_click_count;
                r_draw        <= n_draw;
                r_theme       <= n_theme;
                r_speed       <= n_speed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
        if (w_step) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTH
    a_long_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.event_code == EV_LONG)
        |-> o_out_data.stable_level && r_long_done && (r_click_count == '0))
        else $error("long press result without held, latched state");

    a_click_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_out_data.event_code == EV_SINGLE) ||
                        (o_out_data.event_code == EV_MULTI))
        |-> !o_out_data.stable_level && (r_click_count == '0))
        else $error("click result while pressed or with clicks left pending");

    a_style_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.draw_style != 2'd3) &&
                        (o_out_data.theme_style != 2'd3))
        else $error("draw or theme style out of range");

    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_speed <= SPEED_LAST)
        else $error("speed index beyond last preset");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_step |=> $stable(r_click_count) && $stable(r_draw) && $stable(r_speed))
        else $error("gesture state changed without an item");
`endif

endmodule
